FILE: sv/assert_macros.svh
// Assertion helpers shared by the SPI master modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SPIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the following clock edge.
`define SPIM_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: sv/spim_pkg.sv
`default_nettype none

package spim_pkg;

  // Chip-select lines that the hardware can ever address.
  localparam int MAX_SELECTS = 8;

  // Entries in the queue between the front end and the bit engine.
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLOCK_MODE   = 2'd0;
  localparam logic [1:0] CFG_LSB_ORDER    = 2'd1;
  localparam logic [1:0] CFG_HALF_PERIOD  = 2'd2;
  localparam logic [1:0] CFG_SELECT_COUNT = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_BUSY    = 2'd2
  } status_t;

  // One classified command as it travels from the front end to the engine.
  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] idx;
    logic       sel_ok;
    logic [7:0] tx_byte;
    logic       miso;
  } item_t;

  // Position in the shift registers of the bit being moved, given the
  // number of bits still to go.
  function automatic logic [2:0] bit_pos(input logic [3:0] bits_left, input logic lsb);
    logic [2:0] n;
    n = 3'(BITS_PER_BYTE - bits_left);
    return lsb ? n : (3'd7 - n);
  endfunction

endpackage

`default_nettype wire

FILE: sv/spim_front.sv
`default_nettype none
`include "assert_macros.svh"

module spim_front
  import spim_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [2:0] select_index,
  input  wire logic [7:0] tx_byte,
  input  wire logic       miso_level,
  input  wire logic [3:0] select_count,
  output logic            q_valid,
  output item_t           q_item,
  input  wire logic       q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  item_t              incoming;
  logic               push;

  // Classify the command. The range check of the select index is done here
  // so the engine only has to act on a ready-made flag.
  always_comb begin
    incoming.cmd     = cmd_t'(cmd);
    incoming.idx     = select_index;
    incoming.sel_ok  = ({1'b0, select_index} < select_count)
                       && (32'(select_index) < MAX_SELECTS);
    incoming.tx_byte = tx_byte;
    incoming.miso    = miso_level;
  end

  assign item_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SPIM_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `SPIM_ASSERT_NEXT(a_push_grows, push && !q_pop, count == $past(count) + 1'b1,
                    "queue count did not grow on a lone push")
  `SPIM_ASSERT(a_pop_nonempty, !q_pop || q_valid, "pop from an empty queue")

endmodule

`default_nettype wire

FILE: sv/spim_engine.sv
`default_nettype none
`include "assert_macros.svh"

module spim_engine
  import spim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  input  wire logic        polarity,
  input  wire logic        lsb_order,
  input  wire logic [15:0] half_period,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             sck,
  output logic             mosi,
  output logic [7:0]       select_lines,
  output logic             busy_res,
  output logic [7:0]       rx_byte,
  output logic             rx_valid,
  output logic [1:0]       status
);

  logic        lock_held,   lock_held_next;
  logic [7:0]  select_state, select_state_next;
  logic [7:0]  tx_shift,    tx_shift_next;
  logic [7:0]  rx_shift,    rx_shift_next;
  logic [3:0]  bits_left,   bits_left_next;
  logic        second_half, second_half_next;
  logic [15:0] tick_count,  tick_count_next;
  logic        sck_level,   sck_level_next;
  logic        mosi_level,  mosi_level_next;

  logic        sck_out, mosi_out, rxv_out;
  logic [7:0]  rx_out;
  status_t     st_out;
  logic [15:0] half;
  logic [2:0]  pos;

  assign q_pop = q_valid && (!res_valid || !res_stall);
  assign half  = (half_period == '0) ? 16'd1 : half_period;

  always_comb begin
    lock_held_next    = lock_held;
    select_state_next = select_state;
    tx_shift_next     = tx_shift;
    rx_shift_next     = rx_shift;
    bits_left_next    = bits_left;
    second_half_next  = second_half;
    tick_count_next   = tick_count;
    sck_level_next    = sck_level;
    mosi_level_next   = mosi_level;
    st_out            = ST_OK;
    rxv_out           = 1'b0;
    rx_out            = '0;
    pos               = '0;

    if (bits_left != '0) begin
      if (q_item.cmd != CMD_TICK) begin
        st_out = ST_BUSY;
      end
    end else begin
      unique case (q_item.cmd)
        CMD_OPEN: begin
          if (!lock_held && q_item.sel_ok) begin
            lock_held_next                  = 1'b1;
            select_state_next[q_item.idx]   = 1'b0;
          end else begin
            st_out = ST_REFUSED;
          end
        end
        CMD_CLOSE: begin
          lock_held_next = 1'b0;
          if (q_item.sel_ok) begin
            select_state_next[q_item.idx] = 1'b1;
          end
        end
        CMD_START: begin
          tx_shift_next    = q_item.tx_byte;
          rx_shift_next    = '0;
          bits_left_next   = BITS_PER_BYTE;
          second_half_next = 1'b0;
          tick_count_next  = '0;
          mosi_level_next  = q_item.tx_byte[bit_pos(BITS_PER_BYTE, lsb_order)];
          sck_level_next   = ~polarity;
        end
        default: begin
        end
      endcase
    end

    if (bits_left_next == '0) begin
      sck_level_next = polarity;
      sck_out        = sck_level_next;
      mosi_out       = mosi_level_next;
    end else begin
      sck_out  = sck_level_next;
      mosi_out = mosi_level_next;
      if (({1'b0, tick_count_next} + 17'd1) >= {1'b0, half}) begin
        tick_count_next = '0;
        if (!second_half_next) begin
          pos                 = bit_pos(bits_left_next, lsb_order);
          rx_shift_next[pos]  = q_item.miso;
          second_half_next    = 1'b1;
          sck_level_next      = polarity;
        end else begin
          second_half_next = 1'b0;
          bits_left_next   = bits_left_next - 1'b1;
          if (bits_left_next == '0) begin
            rxv_out        = 1'b1;
            rx_out         = rx_shift_next;
            sck_level_next = polarity;
          end else begin
            pos             = bit_pos(bits_left_next, lsb_order);
            mosi_level_next = tx_shift_next[pos];
            sck_level_next  = ~polarity;
          end
        end
      end else begin
        tick_count_next = tick_count_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_held    <= 1'b0;
      select_state <= 8'hFF;
      tx_shift     <= '0;
      rx_shift     <= '0;
      bits_left    <= '0;
      second_half  <= 1'b0;
      tick_count   <= '0;
      sck_level    <= 1'b0;
      mosi_level   <= 1'b1;
      res_valid    <= 1'b0;
    end else if (q_pop) begin
      lock_held    <= lock_held_next;
      select_state <= select_state_next;
      tx_shift     <= tx_shift_next;
      rx_shift     <= rx_shift_next;
      bits_left    <= bits_left_next;
      second_half  <= second_half_next;
      tick_count   <= tick_count_next;
      sck_level    <= sck_level_next;
      mosi_level   <= mosi_level_next;
      res_valid    <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sck          <= sck_out;
      mosi         <= mosi_out;
      select_lines <= select_state_next;
      busy_res     <= (bits_left_next != '0);
      rx_byte      <= rx_out;
      rx_valid     <= rxv_out;
      status       <= st_out;
    end
  end

  `SPIM_ASSERT(a_bits_bound, bits_left <= BITS_PER_BYTE, "bit counter above eight")
  `SPIM_ASSERT(a_lock_has_select, !lock_held || (select_state != 8'hFF),
               "lock held with no select driven low")
  `SPIM_ASSERT(a_done_not_busy, !(res_valid && rx_valid && busy_res),
               "completed transfer still reports busy")

endmodule

`default_nettype wire

FILE: sv/spi_master_four_mode_top.sv
// SPI master, modes 0 to 3, one command per clock cycle while neither channel stalls.
// Throughput: one input transfer per cycle, sustained, while results are taken.
// On an empty queue a command goes through a queue entry and then the result register.
// The result register and the queue let input and output stall independently.
// Reset (rst, synchronous, active high) empties the queue, releases the lock, raises
// all selects in the engine state, stops any byte and restores the register defaults.
`default_nettype none

module spi_master_four_mode_top
  import spim_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Command channel.
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  select_index,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        miso_level,
  // Result channel.
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             sck,
  output logic             mosi,
  output logic [7:0]       select_lines,
  output logic             busy_res,
  output logic [7:0]       rx_byte,
  output logic             rx_valid,
  output logic [1:0]       status
);

  // Configuration registers. They are read live by both halves; software must
  // change them only while no command is in flight, which the block does not enforce.
  logic [1:0]  clock_mode;
  logic        lsb_order;
  logic [15:0] half_period;
  logic [3:0]  select_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_mode   <= 2'd0;
      lsb_order    <= 1'b0;
      half_period  <= 16'd1;
      select_count <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOCK_MODE:   clock_mode   <= cfg_data[1:0];
        CFG_LSB_ORDER:    lsb_order    <= cfg_data[0];
        CFG_HALF_PERIOD:  half_period  <= cfg_data;
        CFG_SELECT_COUNT: select_count <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // The front end classifies each command and queues it; it stalls the
  // command channel only when the queue is full.
  spim_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .select_index (select_index),
    .tx_byte      (tx_byte),
    .miso_level   (miso_level),
    .select_count (select_count),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // The engine runs one tick of the bit clock generator per queued command
  // and holds the result in its output register until it is taken. Clock
  // phase does not alter the waveform, so only the polarity bit is used.
  spim_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .polarity     (clock_mode[1]),
    .lsb_order    (lsb_order),
    .half_period  (half_period),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .sck          (sck),
    .mosi         (mosi),
    .select_lines (select_lines),
    .busy_res     (busy_res),
    .rx_byte      (rx_byte),
    .rx_valid     (rx_valid),
    .status       (status)
  );

endmodule

`default_nettype wire

FILE: dv/spi_master_four_mode_top_tb.sv
module spi_master_four_mode_top_tb;
  import spim_pkg::*;

  // A run fails if the watchdog limit is reached with no transfer on any port.
  // The longest legal quiet stretch is the forced receiver hold plus a sender gap.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 140;
  localparam int LONG_HOLD_PHASE = 4;
  localparam int PRESSURE_HOLD = 100;

  // Pin levels and flags that the block reports for one command tick.
  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic [7:0] select_lines;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    status_t    status;
  } spi_pins_t;

  // Keeps its own copy of the bus state and the registers, works out the pins
  // for each accepted command and compares them with what the block returns.
  class spi_bus_checker;
    logic [1:0]  clk_mode;
    logic        lsb_order;
    logic [15:0] half_ticks;
    logic [3:0]  line_count;
    logic        locked;
    logic [7:0]  lines;
    logic [7:0]  tx_sr;
    logic [7:0]  rx_sr;
    logic [3:0]  bits_to_go;
    logic        trailing;
    logic [15:0] tick_cnt;
    logic        sck_pin;
    logic        mosi_pin;
    spi_pins_t   expected_pins[$];
    int          errors;

    function new();
      clk_mode = 2'd0;
      lsb_order = 1'b0;
      half_ticks = 16'd1;
      line_count = 4'd1;
      locked = 1'b0;
      lines = 8'hFF;
      tx_sr = 8'h00;
      rx_sr = 8'h00;
      bits_to_go = 4'd0;
      trailing = 1'b0;
      tick_cnt = 16'd0;
      sck_pin = 1'b0;
      mosi_pin = 1'b1;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_CLOCK_MODE:   clk_mode = data[1:0];
        CFG_LSB_ORDER:    lsb_order = data[0];
        CFG_HALF_PERIOD:  half_ticks = data;
        CFG_SELECT_COUNT: line_count = data[3:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_pins.size();
    endfunction

    // Bit of the shift registers that the current bit of the byte occupies.
    function logic [2:0] shift_pos();
      logic [2:0] n;
      n = 3'(4'd8 - bits_to_go);
      return lsb_order ? n : 3'd7 - n;
    endfunction

    function logic line_ok(logic [2:0] idx);
      return ({1'b0, idx} < line_count) && (int'(idx) < MAX_SELECTS);
    endfunction

    // Leading half of a bit: clock leaves its idle level, the new bit goes out.
    function void drive_bit();
      mosi_pin = tx_sr[shift_pos()];
      sck_pin = ~clk_mode[1];
    endfunction

    function void note_command(cmd_t c, logic [2:0] idx, logic [7:0] txb, logic miso);
      spi_pins_t r;
      logic [31:0] half;
      r = '0;
      r.status = ST_OK;
      half = (half_ticks == 16'd0) ? 32'd1 : {16'd0, half_ticks};
      if (bits_to_go != 4'd0) begin
        if (c != CMD_TICK) r.status = ST_BUSY;
      end else begin
        case (c)
          CMD_OPEN: begin
            if (!locked && line_ok(idx)) begin
              locked = 1'b1;
              lines[idx] = 1'b0;
            end else begin
              r.status = ST_REFUSED;
            end
          end
          CMD_CLOSE: begin
            locked = 1'b0;
            if (line_ok(idx)) lines[idx] = 1'b1;
          end
          CMD_START: begin
            tx_sr = txb;
            rx_sr = 8'h00;
            bits_to_go = BITS_PER_BYTE;
            trailing = 1'b0;
            tick_cnt = 16'd0;
            drive_bit();
          end
          default: ;
        endcase
      end
      r.sck = (bits_to_go == 4'd0) ? clk_mode[1] : sck_pin;
      r.mosi = mosi_pin;
      if (bits_to_go == 4'd0) begin
        sck_pin = clk_mode[1];
      end else if ({16'd0, tick_cnt} + 32'd1 >= half) begin
        tick_cnt = 16'd0;
        if (!trailing) begin
          // MISO is taken on the last tick of the leading half in every mode.
          rx_sr[shift_pos()] = miso;
          trailing = 1'b1;
          sck_pin = clk_mode[1];
        end else begin
          trailing = 1'b0;
          bits_to_go = bits_to_go - 4'd1;
          if (bits_to_go == 4'd0) begin
            r.rx_valid = 1'b1;
            r.rx_byte = rx_sr;
            sck_pin = clk_mode[1];
          end else begin
            drive_bit();
          end
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
      r.select_lines = lines;
      r.busy_res = (bits_to_go != 4'd0);
      expected_pins.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pins(spi_pins_t got);
      spi_pins_t want;
      if (expected_pins.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
        return;
      end
      want = expected_pins.pop_front();
      compare_field("sck", 8'(want.sck), 8'(got.sck));
      compare_field("mosi", 8'(want.mosi), 8'(got.mosi));
      compare_field("select_lines", want.select_lines, got.select_lines);
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      compare_field("status", 8'(want.status), 8'(got.status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_CLOCK_MODE;
  logic [15:0] cfg_data = 16'd0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  cmd = CMD_TICK;
  logic [2:0]  select_index = 3'd0;
  logic [7:0]  tx_byte = 8'd0;
  logic        miso_level = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        sck;
  logic        mosi;
  logic [7:0]  select_lines;
  logic        busy_res;
  logic [7:0]  rx_byte;
  logic        rx_valid;
  logic [1:0]  status;

  spi_bus_checker bus = new();

  // Stimulus shaping shared by the driving tasks and the receiver process.
  // steady turns off all random idling for one phase, hold_due asks the
  // receiver for one long hold, busy_est is a rough count of the ticks left in
  // the byte on the wire so that most commands land while the bus is free.
  bit          steady = 1'b0;
  bit          hold_due = 1'b0;
  int          busy_est = 0;
  logic [15:0] cur_half = 16'd1;
  int          quiet_cycles = 0;

  spi_master_four_mode_top i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Everything is sampled at the rising edge with pre-edge values, so the
  // checker sees exactly what the block saw. Register writes only happen
  // while nothing is in flight, so their order against the rest is moot.
  always @(posedge clk) begin
    spi_pins_t got;
    if (!rst) begin
      if (cfg_we) bus.write_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall) begin
        bus.note_command(cmd_t'(cmd), select_index, tx_byte, miso_level);
      end
      if (res_valid && !res_stall) begin
        got.sck = sck;
        got.mosi = mosi;
        got.select_lines = select_lines;
        got.busy_res = busy_res;
        got.rx_byte = rx_byte;
        got.rx_valid = rx_valid;
        got.status = status_t'(status);
        bus.check_pins(got);
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_we || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Receiver side. Stall stretches alternate with open stretches, and the
  // open stretches are sometimes long so that the block runs flat out.
  // One long hold (PRESSURE_HOLD) lets the internal queue fill up so that
  // the block has to stall its command input.
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_due) begin
        n = PRESSURE_HOLD;
        hold_due = 1'b0;
      end else if (steady) begin
        n = 0;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  // Offers one command and returns in the time step of the edge that took it.
  // The payload holds still while the block stalls.
  task automatic send_item(input cmd_t c, input logic [2:0] idx, input logic [7:0] b,
                           input logic miso);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    select_index <= idx;
    tx_byte <= b;
    miso_level <= miso;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
  endtask

  // Random command. While a byte is probably still on the wire most ticks are
  // plain ticks, with a few commands that the block has to reject as busy.
  // On a free bus the stream is made of opens, byte starts, closes and plain ticks.
  task automatic send_random_item();
    cmd_t       c;
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (busy_est > 0) begin
      c = (r < 88) ? CMD_TICK : cmd_t'($urandom_range(1, 3));
      busy_est--;
    end else begin
      if (r < 35) c = CMD_OPEN;
      else if (r < 70) c = CMD_START;
      else if (r < 90) c = CMD_CLOSE;
      else c = CMD_TICK;
      if (c == CMD_START) busy_est = 16 * ((cur_half == 16'd0) ? 1 : int'(cur_half)) - 1;
    end
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    send_item(c, 3'($urandom), b, 1'($urandom));
  endtask

  // Lowers valid and waits until every transfer has its result, so that no
  // register write can overtake a command still queued inside the block.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (bus.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes all four registers back to back. The unused upper data bits carry
  // random junk, which the block has to ignore.
  task automatic set_config(input logic [1:0] mode, input logic lsb, input logic [15:0] half,
                            input logic [3:0] count);
    write_reg(CFG_CLOCK_MODE, {14'($urandom), mode});
    write_reg(CFG_LSB_ORDER, {15'($urandom), lsb});
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_SELECT_COUNT, {12'($urandom), count});
    cfg_we <= 1'b0;
    cur_half = half;
  endtask

  initial begin : stimulus
    int p;
    int k;
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed start on the reset settings: mode 0, MSB first, one tick per
    // half and a single select line.
    send_item(CMD_OPEN, 3'd0, 8'h00, 1'b0);   // takes the lock, line 0 goes low
    send_item(CMD_OPEN, 3'd0, 8'h00, 1'b0);   // refused, the lock is held
    send_item(CMD_CLOSE, 3'd5, 8'h00, 1'b0);  // out of range: only frees the lock
    send_item(CMD_OPEN, 3'd1, 8'h00, 1'b0);   // out of range, refused
    send_item(CMD_OPEN, 3'd0, 8'h00, 1'b0);
    send_item(CMD_START, 3'd7, 8'hFF, 1'b1);  // all ones out
    // Every command but a tick is rejected as busy while the byte is on the wire.
    send_item(CMD_OPEN, 3'd7, 8'h00, 1'b0);
    send_item(CMD_CLOSE, 3'd0, 8'h00, 1'b1);
    send_item(CMD_START, 3'd3, 8'h00, 1'b0);
    for (k = 0; k < 12; k++) begin
      send_item(CMD_TICK, 3'(k), 8'(k * 37), k[0]);
    end
    send_item(CMD_CLOSE, 3'd0, 8'h00, 1'b0);

    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: set_config(2'd1, 1'b0, 16'd1, 4'd8);
        1: set_config(2'd2, 1'b1, 16'd0, 4'd1);
        2: set_config(2'd3, 1'b1, 16'd2, 4'd0);
        3: set_config(2'd0, 1'b0, 16'd3, 4'd15);
        LONG_HOLD_PHASE: set_config(2'd3, 1'b0, 16'hFFFF, 4'd8);
        default: begin
          set_config(2'($urandom), 1'($urandom), 16'($urandom_range(0, 4)),
                     4'($urandom_range(0, 15)));
        end
      endcase
      steady = (p == 3);
      hold_due = (p == 0);
      busy_est = 0;
      n = PHASE_ITEMS;
      if (p == LONG_HOLD_PHASE) begin
        // The longest half period would need about a million ticks per byte.
        // The byte is only started here; the next phase shortens the half
        // period in mid-byte, which the block has to pick up at once.
        send_item(CMD_START, 3'd2, 8'h5A, 1'b1);
        busy_est = 100;
        n = 40;
      end
      for (k = 0; k < n; k++) begin
        send_random_item();
      end
    end

    steady = 1'b0;
    settle();
    if (bus.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
